FILE: rtl/idsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idsa_pkg
// Types and constants shared by the implicit diffusion stencil pipeline.
// ----------------------------------------------------------------------------
package idsa_pkg;

   localparam int VALUE_W     = 32;
   localparam int COORD_W     = 12;
   localparam int SIDE_W      = 13;
   localparam int COEF_W      = 31;
   localparam int MASK_W      = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int FRAC_BITS   = 16;

   localparam logic [SIDE_W-1:0] GRID_SIDE_MIN = 13'd3;
   localparam logic [SIDE_W-1:0] GRID_SIDE_MAX = 13'd4096;

   localparam int MASK_TOP    = 0;
   localparam int MASK_BOTTOM = 1;
   localparam int MASK_LEFT   = 2;
   localparam int MASK_RIGHT  = 3;

   localparam int DIAG_W  = 33;
   localparam int TERM_W  = 34;
   localparam int NSUM_W  = 36;
   localparam int AX_W    = 64;
   localparam int DIFF_W  = 66;
   localparam int MAG_W   = 65;
   localparam int CHUNK_W = 32;
   localparam int PART_W  = CHUNK_W + COEF_W;
   localparam int PROD_W  = 96;
   localparam int ROUND_SHIFT = 2 * FRAC_BITS;
   localparam int QUOT_W  = PROD_W - ROUND_SHIFT;
   localparam int SAT_BIT = 40;
   localparam int SUM_W   = 43;

   localparam logic [DIAG_W-1:0] DIAG_FOUR = 33'(4) << FRAC_BITS;
   localparam logic [PROD_W-1:0] ROUND_HALF = 96'(1) << (ROUND_SHIFT - 1);

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FOURIER_NUMBER    = 3'd0,
      CSR_TOP_ROBIN_TERM    = 3'd1,
      CSR_BOTTOM_ROBIN_TERM = 3'd2,
      CSR_LEFT_ROBIN_TERM   = 3'd3,
      CSR_RIGHT_ROBIN_TERM  = 3'd4,
      CSR_WALL_NEUMANN_MASK = 3'd5,
      CSR_GRID_WIDTH        = 3'd6,
      CSR_GRID_HEIGHT       = 3'd7
   } idsa_csr_type;

   typedef enum logic [1:0] {
      WEIGHT_ZERO = 2'd0,
      WEIGHT_ONE  = 2'd1,
      WEIGHT_TWO  = 2'd2
   } idsa_weight_type;

   typedef struct packed {
      logic [COEF_W-1:0] fourier_number;
      logic [COEF_W-1:0] top_robin_term;
      logic [COEF_W-1:0] bottom_robin_term;
      logic [COEF_W-1:0] left_robin_term;
      logic [COEF_W-1:0] right_robin_term;
      logic [MASK_W-1:0] wall_neumann_mask;
      logic [SIDE_W-1:0] grid_width;
      logic [SIDE_W-1:0] grid_height;
   } idsa_cfg_type;

   localparam idsa_cfg_type CFG_RESET = '{
      fourier_number:    '0,
      top_robin_term:    '0,
      bottom_robin_term: '0,
      left_robin_term:   '0,
      right_robin_term:  '0,
      wall_neumann_mask: '0,
      grid_width:        GRID_SIDE_MIN,
      grid_height:       GRID_SIDE_MIN
   };

   typedef struct packed {
      logic signed [VALUE_W-1:0] center_value;
      logic signed [VALUE_W-1:0] below_value;
      logic signed [VALUE_W-1:0] above_value;
      logic signed [VALUE_W-1:0] left_value;
      logic signed [VALUE_W-1:0] right_value;
      logic [COORD_W-1:0]        column;
      logic [COORD_W-1:0]        row;
   } idsa_node_type;

   typedef struct packed {
      logic                      pass;
      logic signed [VALUE_W-1:0] x;
      logic [VALUE_W-1:0]        x_mag;
      logic [DIAG_W-1:0]         s;
      logic signed [TERM_W-1:0]  term_below;
      logic signed [TERM_W-1:0]  term_above;
      logic signed [TERM_W-1:0]  term_left;
      logic signed [TERM_W-1:0]  term_right;
   } idsa_dec_type;

   typedef struct packed {
      logic                      pass;
      logic signed [VALUE_W-1:0] x;
      logic                      neg;
      logic [MAG_W-1:0]          mag;
   } idsa_mag_type;

endpackage

FILE: rtl/idsa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idsa_req_if / idsa_rsp_if
// Valid/ready channels for grid node transactions and operator results.
// ----------------------------------------------------------------------------
interface idsa_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [idsa_pkg::VALUE_W-1:0] center_value;
   logic signed [idsa_pkg::VALUE_W-1:0] below_value;
   logic signed [idsa_pkg::VALUE_W-1:0] above_value;
   logic signed [idsa_pkg::VALUE_W-1:0] left_value;
   logic signed [idsa_pkg::VALUE_W-1:0] right_value;
   logic [idsa_pkg::COORD_W-1:0]        column;
   logic [idsa_pkg::COORD_W-1:0]        row;

   modport source (
      output valid, center_value, below_value, above_value, left_value, right_value,
      output column, row,
      input  ready
   );
   modport sink (
      input  valid, center_value, below_value, above_value, left_value, right_value,
      input  column, row,
      output ready
   );
endinterface

interface idsa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [idsa_pkg::VALUE_W-1:0] operator_value;
   logic                                saturated;

   modport source (output valid, operator_value, saturated, input ready);
   modport sink (input valid, operator_value, saturated, output ready);
endinterface

FILE: rtl/idsa_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idsa_decode
// Node classification stage: wall and corner detection, weights, diagonal.
// ----------------------------------------------------------------------------
module idsa_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  idsa_pkg::idsa_cfg_type cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  idsa_pkg::idsa_node_type in_node,
   output logic                   out_valid,
   input  logic                   out_ready,
   output idsa_pkg::idsa_dec_type out_dec
);

   function automatic logic [idsa_pkg::SIDE_W-1:0] clamp_side(
      input logic [idsa_pkg::SIDE_W-1:0] v
   );
      logic [idsa_pkg::SIDE_W-1:0] r;
      priority if (v < idsa_pkg::GRID_SIDE_MIN) r = idsa_pkg::GRID_SIDE_MIN;
      else if (v > idsa_pkg::GRID_SIDE_MAX) r = idsa_pkg::GRID_SIDE_MAX;
      else r = v;
      return r;
   endfunction

   function automatic logic signed [idsa_pkg::TERM_W-1:0] weigh(
      input logic signed [idsa_pkg::VALUE_W-1:0] v,
      input idsa_pkg::idsa_weight_type           w
   );
      logic signed [idsa_pkg::TERM_W-1:0] r;
      unique case (w)
         idsa_pkg::WEIGHT_ZERO: r = '0;
         idsa_pkg::WEIGHT_ONE:  r = idsa_pkg::TERM_W'(v);
         idsa_pkg::WEIGHT_TWO:  r = idsa_pkg::TERM_W'(v) <<< 1;
         default:               r = '0;
      endcase
      return r;
   endfunction

   logic                           valid_ff;
   logic                           valid_in;
   logic                           enable;
   idsa_pkg::idsa_dec_type         dec_ff;
   idsa_pkg::idsa_dec_type         dec_in;

   logic [idsa_pkg::SIDE_W-1:0]    w_side;
   logic [idsa_pkg::SIDE_W-1:0]    h_side;
   logic [idsa_pkg::SIDE_W-1:0]    col13;
   logic [idsa_pkg::SIDE_W-1:0]    row13;
   logic                           outside;
   logic                           top;
   logic                           bot;
   logic                           lc;
   logic                           rc;
   logic                           tn;
   logic                           bn;
   logic                           ln;
   logic                           rn;
   logic                           pass;
   idsa_pkg::idsa_weight_type      wb;
   idsa_pkg::idsa_weight_type      wa;
   idsa_pkg::idsa_weight_type      wl;
   idsa_pkg::idsa_weight_type      wr;
   logic [idsa_pkg::COEF_W:0]      s_add;
   logic signed [idsa_pkg::VALUE_W-1:0] vb;
   logic signed [idsa_pkg::VALUE_W-1:0] va;
   logic signed [idsa_pkg::VALUE_W-1:0] vl;
   logic signed [idsa_pkg::VALUE_W-1:0] vr;

   assign enable    = !valid_ff || out_ready;
   assign in_ready  = enable;
   assign out_valid = valid_ff;
   assign out_dec   = dec_ff;

   always_comb begin
      w_side  = clamp_side(cfg.grid_width);
      h_side  = clamp_side(cfg.grid_height);
      col13   = {1'b0, in_node.column};
      row13   = {1'b0, in_node.row};
      outside = (col13 >= w_side) || (row13 >= h_side);
      top     = row13 == (h_side - 13'd1);
      bot     = row13 == '0;
      lc      = col13 == '0;
      rc      = col13 == (w_side - 13'd1);
      tn      = cfg.wall_neumann_mask[idsa_pkg::MASK_TOP];
      bn      = cfg.wall_neumann_mask[idsa_pkg::MASK_BOTTOM];
      ln      = cfg.wall_neumann_mask[idsa_pkg::MASK_LEFT];
      rn      = cfg.wall_neumann_mask[idsa_pkg::MASK_RIGHT];
      vb      = bot ? '0 : in_node.below_value;
      va      = top ? '0 : in_node.above_value;
      vl      = lc  ? '0 : in_node.left_value;
      vr      = rc  ? '0 : in_node.right_value;
   end

   always_comb begin
      wb    = idsa_pkg::WEIGHT_ONE;
      wa    = idsa_pkg::WEIGHT_ONE;
      wl    = idsa_pkg::WEIGHT_ONE;
      wr    = idsa_pkg::WEIGHT_ONE;
      s_add = '0;
      pass  = 1'b0;
      priority if (outside) begin
         pass = 1'b1;
      end else if (!(top || bot || lc || rc)) begin
         s_add = '0;
      end else if (tn && top) begin
         wa = idsa_pkg::WEIGHT_ZERO;
         wb = idsa_pkg::WEIGHT_TWO;
         priority if (lc && ln) begin
            wl    = idsa_pkg::WEIGHT_ZERO;
            wr    = idsa_pkg::WEIGHT_TWO;
            s_add = {1'b0, cfg.top_robin_term} + {1'b0, cfg.left_robin_term};
         end else if (rc && rn) begin
            wr    = idsa_pkg::WEIGHT_ZERO;
            wl    = idsa_pkg::WEIGHT_TWO;
            s_add = {1'b0, cfg.top_robin_term} + {1'b0, cfg.right_robin_term};
         end else begin
            s_add = {1'b0, cfg.top_robin_term};
         end
      end else if (bn && bot) begin
         wb = idsa_pkg::WEIGHT_ZERO;
         wa = idsa_pkg::WEIGHT_TWO;
         priority if (lc && ln) begin
            wl    = idsa_pkg::WEIGHT_ZERO;
            wr    = idsa_pkg::WEIGHT_TWO;
            s_add = {1'b0, cfg.left_robin_term} + {1'b0, cfg.bottom_robin_term};
         end else if (rc && rn) begin
            wr    = idsa_pkg::WEIGHT_ZERO;
            wl    = idsa_pkg::WEIGHT_TWO;
            s_add = {1'b0, cfg.right_robin_term} + {1'b0, cfg.bottom_robin_term};
         end else begin
            s_add = {1'b0, cfg.bottom_robin_term};
         end
      end else if (ln && lc && !top && !bot) begin
         wl    = idsa_pkg::WEIGHT_ZERO;
         wr    = idsa_pkg::WEIGHT_TWO;
         s_add = {1'b0, cfg.left_robin_term};
      end else if (rn && rc && !top && !bot) begin
         wr    = idsa_pkg::WEIGHT_ZERO;
         wl    = idsa_pkg::WEIGHT_TWO;
         s_add = {1'b0, cfg.right_robin_term};
      end else begin
         pass = 1'b1;
      end
   end

   always_comb begin
      valid_in = enable ? in_valid : valid_ff;
      dec_in   = dec_ff;
      if (enable) begin
         dec_in.pass       = pass;
         dec_in.x          = in_node.center_value;
         dec_in.x_mag      = in_node.center_value[idsa_pkg::VALUE_W-1]
                           ? (~in_node.center_value + 32'd1) : in_node.center_value;
         dec_in.s          = idsa_pkg::DIAG_FOUR + idsa_pkg::DIAG_W'(s_add);
         dec_in.term_below = weigh(vb, wb);
         dec_in.term_above = weigh(va, wa);
         dec_in.term_left  = weigh(vl, wl);
         dec_in.term_right = weigh(vr, wr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dec_ff <= dec_in;
   end

endmodule

FILE: rtl/idsa_diff.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idsa_diff
// Forms S*x - N*2^fb exactly over three stages and splits sign and magnitude.
// ----------------------------------------------------------------------------
module idsa_diff (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  idsa_pkg::idsa_dec_type in_dec,
   output logic                   out_valid,
   input  logic                   out_ready,
   output idsa_pkg::idsa_mag_type out_mag
);

   typedef struct packed {
      logic                                pass;
      logic signed [idsa_pkg::VALUE_W-1:0] x;
      logic [idsa_pkg::AX_W-1:0]           prod;
      logic signed [idsa_pkg::NSUM_W-1:0]  nsum;
   } prod_stage_type;

   typedef struct packed {
      logic                                pass;
      logic signed [idsa_pkg::VALUE_W-1:0] x;
      logic signed [idsa_pkg::DIFF_W-1:0]  diff;
   } diff_stage_type;

   logic                   valid2_ff;
   logic                   valid2_in;
   logic                   valid3_ff;
   logic                   valid3_in;
   logic                   valid4_ff;
   logic                   valid4_in;
   logic                   en2;
   logic                   en3;
   logic                   en4;
   prod_stage_type         st2_ff;
   prod_stage_type         st2_in;
   diff_stage_type         st3_ff;
   diff_stage_type         st3_in;
   idsa_pkg::idsa_mag_type st4_ff;
   idsa_pkg::idsa_mag_type st4_in;
   logic signed [idsa_pkg::DIFF_W-1:0] prod_s;
   logic signed [idsa_pkg::DIFF_W-1:0] nsum_s;
   logic signed [idsa_pkg::DIFF_W-1:0] mag_s;

   assign en4       = !valid4_ff || out_ready;
   assign en3       = !valid3_ff || en4;
   assign en2       = !valid2_ff || en3;
   assign in_ready  = en2;
   assign out_valid = valid4_ff;
   assign out_mag   = st4_ff;

   always_comb begin
      valid2_in = en2 ? in_valid : valid2_ff;
      st2_in    = st2_ff;
      if (en2) begin
         st2_in.pass = in_dec.pass;
         st2_in.x    = in_dec.x;
         st2_in.prod = idsa_pkg::AX_W'(in_dec.s) * idsa_pkg::AX_W'(in_dec.x_mag);
         st2_in.nsum = idsa_pkg::NSUM_W'(in_dec.term_below)
                     + idsa_pkg::NSUM_W'(in_dec.term_above)
                     + idsa_pkg::NSUM_W'(in_dec.term_left)
                     + idsa_pkg::NSUM_W'(in_dec.term_right);
      end
   end

   always_comb begin
      prod_s    = $signed({2'b00, st2_ff.prod});
      nsum_s    = idsa_pkg::DIFF_W'(st2_ff.nsum) <<< idsa_pkg::FRAC_BITS;
      valid3_in = en3 ? valid2_ff : valid3_ff;
      st3_in    = st3_ff;
      if (en3) begin
         st3_in.pass = st2_ff.pass;
         st3_in.x    = st2_ff.x;
         st3_in.diff = (st2_ff.x[idsa_pkg::VALUE_W-1] ? -prod_s : prod_s) - nsum_s;
      end
   end

   always_comb begin
      mag_s     = st3_ff.diff[idsa_pkg::DIFF_W-1] ? -st3_ff.diff : st3_ff.diff;
      valid4_in = en4 ? valid3_ff : valid4_ff;
      st4_in    = st4_ff;
      if (en4) begin
         st4_in.pass = st3_ff.pass;
         st4_in.x    = st3_ff.x;
         st4_in.neg  = st3_ff.diff[idsa_pkg::DIFF_W-1];
         st4_in.mag  = mag_s[idsa_pkg::MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         valid2_ff <= valid2_in;
         valid3_ff <= valid3_in;
         valid4_ff <= valid4_in;
      end
   end

   always_ff @(posedge clock) begin
      st2_ff <= st2_in;
      st3_ff <= st3_in;
      st4_ff <= st4_in;
   end

endmodule

FILE: rtl/idsa_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idsa_scale
// Scales the magnitude by the Fourier number in partial products, rounds,
// adds x back and saturates into the output register.
// ----------------------------------------------------------------------------
module idsa_scale (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [idsa_pkg::COEF_W-1:0]         fourier_number,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  idsa_pkg::idsa_mag_type              in_mag,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [idsa_pkg::VALUE_W-1:0] operator_value,
   output logic                                saturated
);

   typedef struct packed {
      logic                                pass;
      logic signed [idsa_pkg::VALUE_W-1:0] x;
      logic                                neg;
      logic [idsa_pkg::PART_W-1:0]         p_lo;
      logic [idsa_pkg::PART_W-1:0]         p_hi;
      logic                                top;
   } part_stage_type;

   typedef struct packed {
      logic                                pass;
      logic signed [idsa_pkg::VALUE_W-1:0] x;
      logic                                neg;
      logic                                big;
      logic [idsa_pkg::SAT_BIT:0]          m;
   } round_stage_type;

   logic                                valid5_ff;
   logic                                valid5_in;
   logic                                valid6_ff;
   logic                                valid6_in;
   logic                                valid7_ff;
   logic                                valid7_in;
   logic                                en5;
   logic                                en6;
   logic                                en7;
   part_stage_type                      st5_ff;
   part_stage_type                      st5_in;
   round_stage_type                     st6_ff;
   round_stage_type                     st6_in;
   logic signed [idsa_pkg::VALUE_W-1:0] y_ff;
   logic signed [idsa_pkg::VALUE_W-1:0] y_in;
   logic                                sat_ff;
   logic                                sat_in;
   logic [idsa_pkg::PROD_W-1:0]         acc;
   logic [idsa_pkg::QUOT_W-1:0]         quot;
   logic signed [idsa_pkg::SUM_W-1:0]   q;
   logic signed [idsa_pkg::SUM_W-1:0]   t;

   assign en7            = !valid7_ff || out_ready;
   assign en6            = !valid6_ff || en7;
   assign en5            = !valid5_ff || en6;
   assign in_ready       = en5;
   assign out_valid      = valid7_ff;
   assign operator_value = y_ff;
   assign saturated      = sat_ff;

   always_comb begin
      valid5_in = en5 ? in_valid : valid5_ff;
      st5_in    = st5_ff;
      if (en5) begin
         st5_in.pass = in_mag.pass;
         st5_in.x    = in_mag.x;
         st5_in.neg  = in_mag.neg;
         st5_in.p_lo = {31'b0, in_mag.mag[idsa_pkg::CHUNK_W-1:0]}
                     * {32'b0, fourier_number};
         st5_in.p_hi = {31'b0, in_mag.mag[2*idsa_pkg::CHUNK_W-1:idsa_pkg::CHUNK_W]}
                     * {32'b0, fourier_number};
         st5_in.top  = in_mag.mag[idsa_pkg::MAG_W-1];
      end
   end

   always_comb begin
      acc = {33'b0, st5_ff.p_lo}
          + {1'b0, st5_ff.p_hi, 32'b0}
          + (st5_ff.top ? {1'b0, fourier_number, 64'b0} : '0)
          + idsa_pkg::ROUND_HALF;
      quot      = acc[idsa_pkg::PROD_W-1:idsa_pkg::ROUND_SHIFT];
      valid6_in = en6 ? valid5_ff : valid6_ff;
      st6_in    = st6_ff;
      if (en6) begin
         st6_in.pass = st5_ff.pass;
         st6_in.x    = st5_ff.x;
         st6_in.neg  = st5_ff.neg;
         st6_in.big  = (|quot[idsa_pkg::QUOT_W-1:idsa_pkg::SAT_BIT+1])
                     || (quot[idsa_pkg::SAT_BIT] && (|quot[idsa_pkg::SAT_BIT-1:0]));
         st6_in.m    = quot[idsa_pkg::SAT_BIT:0];
      end
   end

   always_comb begin
      q = st6_ff.neg ? -$signed({2'b00, st6_ff.m}) : $signed({2'b00, st6_ff.m});
      t = idsa_pkg::SUM_W'(st6_ff.x) + q;
      priority if (st6_ff.pass) begin
         y_in   = st6_ff.x;
         sat_in = 1'b0;
      end else if (st6_ff.big) begin
         y_in   = st6_ff.neg ? idsa_pkg::VALUE_MIN : idsa_pkg::VALUE_MAX;
         sat_in = 1'b1;
      end else if (t > idsa_pkg::SUM_W'(idsa_pkg::VALUE_MAX)) begin
         y_in   = idsa_pkg::VALUE_MAX;
         sat_in = 1'b1;
      end else if (t < idsa_pkg::SUM_W'(idsa_pkg::VALUE_MIN)) begin
         y_in   = idsa_pkg::VALUE_MIN;
         sat_in = 1'b1;
      end else begin
         y_in   = t[idsa_pkg::VALUE_W-1:0];
         sat_in = 1'b0;
      end
      valid7_in = en7 ? valid6_ff : valid7_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid5_ff <= 1'b0;
         valid6_ff <= 1'b0;
         valid7_ff <= 1'b0;
      end else begin
         valid5_ff <= valid5_in;
         valid6_ff <= valid6_in;
         valid7_ff <= valid7_in;
      end
   end

   always_ff @(posedge clock) begin
      st5_ff <= st5_in;
      st6_ff <= st6_in;
      if (en7) begin
         y_ff   <= y_in;
         sat_ff <= sat_in;
      end
   end

endmodule

FILE: rtl/implicit_diffusion_stencil_apply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// implicit_diffusion_stencil_apply
// Implicit diffusion operator at one grid node, five-point stencil with
// Dirichlet or Robin/Neumann walls, signed Q16.16 with saturation.
//
// Channel     Dir  Handshake     Payload
// req_stream  in   valid/ready   center/below/above/left/right value, column, row
// rsp_stream  out  valid/ready   operator_value, saturated
// csr_*       in   write enable  csr_index, csr_write_data
//
// One transaction per cycle while rsp_stream is ready; the stages are
// decode, product and neighbor sum, difference, magnitude, partial products,
// round, saturate. The Fourier scaling uses partial products of 32-bit chunks.
// Reset clears every valid bit and returns the configuration registers to
// their reset values.
// A stall holds each full stage; empty stages keep filling behind it.
// ----------------------------------------------------------------------------
module implicit_diffusion_stencil_apply (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [idsa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [idsa_pkg::COEF_W-1:0]       csr_write_data,
   idsa_req_if.sink                          req_stream,
   idsa_rsp_if.source                        rsp_stream
);

   idsa_pkg::idsa_cfg_type  cfg_ff;
   idsa_pkg::idsa_cfg_type  cfg_in;
   idsa_pkg::idsa_node_type node;
   idsa_pkg::idsa_dec_type  dec;
   idsa_pkg::idsa_mag_type  mag;
   logic                    dec_valid;
   logic                    dec_ready;
   logic                    mag_valid;
   logic                    mag_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (idsa_pkg::idsa_csr_type'(csr_index))
            idsa_pkg::CSR_FOURIER_NUMBER:    cfg_in.fourier_number    = csr_write_data;
            idsa_pkg::CSR_TOP_ROBIN_TERM:    cfg_in.top_robin_term    = csr_write_data;
            idsa_pkg::CSR_BOTTOM_ROBIN_TERM: cfg_in.bottom_robin_term = csr_write_data;
            idsa_pkg::CSR_LEFT_ROBIN_TERM:   cfg_in.left_robin_term   = csr_write_data;
            idsa_pkg::CSR_RIGHT_ROBIN_TERM:  cfg_in.right_robin_term  = csr_write_data;
            idsa_pkg::CSR_WALL_NEUMANN_MASK: begin
               cfg_in.wall_neumann_mask = csr_write_data[idsa_pkg::MASK_W-1:0];
            end
            idsa_pkg::CSR_GRID_WIDTH: begin
               cfg_in.grid_width = csr_write_data[idsa_pkg::SIDE_W-1:0];
            end
            idsa_pkg::CSR_GRID_HEIGHT: begin
               cfg_in.grid_height = csr_write_data[idsa_pkg::SIDE_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= idsa_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      node.center_value = req_stream.center_value;
      node.below_value  = req_stream.below_value;
      node.above_value  = req_stream.above_value;
      node.left_value   = req_stream.left_value;
      node.right_value  = req_stream.right_value;
      node.column       = req_stream.column;
      node.row          = req_stream.row;
   end

   idsa_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_stream.valid),
      .in_ready  (req_stream.ready),
      .in_node   (node),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_dec   (dec)
   );

   idsa_diff u_diff (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_dec    (dec),
      .out_valid (mag_valid),
      .out_ready (mag_ready),
      .out_mag   (mag)
   );

   idsa_scale u_scale (
      .clock          (clock),
      .reset          (reset),
      .fourier_number (cfg_ff.fourier_number),
      .in_valid       (mag_valid),
      .in_ready       (mag_ready),
      .in_mag         (mag),
      .out_valid      (rsp_stream.valid),
      .out_ready      (rsp_stream.ready),
      .operator_value (rsp_stream.operator_value),
      .saturated      (rsp_stream.saturated)
   );

endmodule

FILE: rtl/idsa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idsa_checker
// Port-level checks on the stencil pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module idsa_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [idsa_pkg::VALUE_W-1:0] operator_value,
   input logic                                saturated
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result transaction dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(operator_value) && $stable(saturated))
      else $error("result payload changed while stalled");

   a_sat_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && saturated |->
         operator_value == idsa_pkg::VALUE_MAX || operator_value == idsa_pkg::VALUE_MIN)
      else $error("saturated result is not a clamp value");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("pipeline refuses a transaction with an empty output stage");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind implicit_diffusion_stencil_apply idsa_checker u_idsa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_stream.ready),
   .rsp_valid      (rsp_stream.valid),
   .rsp_ready      (rsp_stream.ready),
   .operator_value (rsp_stream.operator_value),
   .saturated      (rsp_stream.saturated)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the implicit diffusion stencil operator. A short
// table of grid nodes covers reset state, every wall and corner form, nodes
// outside the grid and saturation. Random node streams follow under many
// register settings. Results are checked against typed values or a bit-exact
// model, with random idle cycles on the request and response channels.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CLOCK_PERIOD = 8;
   localparam int RANDOM_NODES = 1400;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_LIMIT = 10;
   localparam int DIR_ROWS     = 25;
   localparam int S_W          = idsa_pkg::DIAG_W + 1;

   typedef struct {
      logic signed [idsa_pkg::VALUE_W-1:0] value;
      logic                                sat;
   } op_result_type;

   typedef struct {
      int                      phase;
      idsa_pkg::idsa_node_type node;
      bit                      typed;
      op_result_type           want;
   } dir_row_type;

   logic                             clock;
   logic                             reset;
   logic                             csr_write_enable;
   logic [idsa_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [idsa_pkg::COEF_W-1:0]      csr_write_data;

   idsa_req_if req_if ();
   idsa_rsp_if rsp_if ();

   idsa_pkg::idsa_cfg_type cfg;
   op_result_type          stencil_results[$];
   dir_row_type            dir_table[DIR_ROWS];
   int                     mismatches   = 0;
   int                     cycles       = 0;
   int                     sender_count = 0;
   bit                     sender_quiet = 1'b0;

   implicit_diffusion_stencil_apply uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_stream       (req_if),
      .rsp_stream       (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic logic [idsa_pkg::SIDE_W-1:0] side_in_use(
      logic [idsa_pkg::SIDE_W-1:0] v
   );
      if (v < idsa_pkg::GRID_SIDE_MIN) return idsa_pkg::GRID_SIDE_MIN;
      if (v > idsa_pkg::GRID_SIDE_MAX) return idsa_pkg::GRID_SIDE_MAX;
      return v;
   endfunction

   function automatic op_result_type stencil_operator(idsa_pkg::idsa_node_type nd,
                                                      idsa_pkg::idsa_cfg_type c);
      op_result_type               res;
      logic [idsa_pkg::SIDE_W-1:0] w, h;
      longint                      x, vb, va, vl, vr, n, q, t;
      longint                      wb, wa, wl, wr;
      logic [S_W-1:0]              s, four;
      bit                          pass, top, bot, lc, rc, tn, bn, ln, rn, neg;
      logic signed [79:0]          s80, x80, n80, diff;
      logic [79:0]                 mag;
      logic [127:0]                prod, quot;
      w = side_in_use(c.grid_width);
      h = side_in_use(c.grid_height);
      x = longint'(nd.center_value);
      vb = longint'(nd.below_value);
      va = longint'(nd.above_value);
      vl = longint'(nd.left_value);
      vr = longint'(nd.right_value);
      tn = c.wall_neumann_mask[idsa_pkg::MASK_TOP];
      bn = c.wall_neumann_mask[idsa_pkg::MASK_BOTTOM];
      ln = c.wall_neumann_mask[idsa_pkg::MASK_LEFT];
      rn = c.wall_neumann_mask[idsa_pkg::MASK_RIGHT];
      wb = 1;
      wa = 1;
      wl = 1;
      wr = 1;
      four = S_W'(idsa_pkg::DIAG_FOUR);
      s = four;
      pass = 1'b0;
      top = 1'b0;
      bot = 1'b0;
      lc = 1'b0;
      rc = 1'b0;
      if (idsa_pkg::SIDE_W'(nd.column) >= w || idsa_pkg::SIDE_W'(nd.row) >= h) begin
         pass = 1'b1;
      end else begin
         top = idsa_pkg::SIDE_W'(nd.row) == h - idsa_pkg::SIDE_W'(1);
         bot = nd.row == '0;
         lc = nd.column == '0;
         rc = idsa_pkg::SIDE_W'(nd.column) == w - idsa_pkg::SIDE_W'(1);
         if (bot) vb = 0;
         if (top) va = 0;
         if (lc) vl = 0;
         if (rc) vr = 0;
         if (top || bot || lc || rc) begin
            if (tn && top) begin
               wa = 0;
               wb = 2;
               if (lc && ln) begin
                  wl = 0;
                  wr = 2;
                  s = four + S_W'(c.top_robin_term) + S_W'(c.left_robin_term);
               end else if (rc && rn) begin
                  wr = 0;
                  wl = 2;
                  s = four + S_W'(c.top_robin_term) + S_W'(c.right_robin_term);
               end else begin
                  s = four + S_W'(c.top_robin_term);
               end
            end else if (bn && bot) begin
               wb = 0;
               wa = 2;
               if (lc && ln) begin
                  wl = 0;
                  wr = 2;
                  s = four + S_W'(c.left_robin_term) + S_W'(c.bottom_robin_term);
               end else if (rc && rn) begin
                  wr = 0;
                  wl = 2;
                  s = four + S_W'(c.right_robin_term) + S_W'(c.bottom_robin_term);
               end else begin
                  s = four + S_W'(c.bottom_robin_term);
               end
            end else if (ln && lc && !top && !bot) begin
               wl = 0;
               wr = 2;
               s = four + S_W'(c.left_robin_term);
            end else if (rn && rc && !top && !bot) begin
               wr = 0;
               wl = 2;
               s = four + S_W'(c.right_robin_term);
            end else begin
               pass = 1'b1;
            end
         end
      end
      res.value = nd.center_value;
      res.sat = 1'b0;
      if (pass) return res;
      n = wb * vb + wa * va + wl * vl + wr * vr;
      s80 = 80'(s);
      x80 = 80'(x);
      n80 = 80'(n);
      diff = s80 * x80 - (n80 <<< idsa_pkg::FRAC_BITS);
      neg = diff < 0;
      mag = neg ? -diff : diff;
      prod = 128'(mag) * 128'(c.fourier_number)
           + (128'd1 << (idsa_pkg::ROUND_SHIFT - 1));
      quot = prod >> idsa_pkg::ROUND_SHIFT;
      if (quot > (128'd1 << idsa_pkg::SAT_BIT)) begin
         res.value = neg ? idsa_pkg::VALUE_MIN : idsa_pkg::VALUE_MAX;
         res.sat = 1'b1;
         return res;
      end
      q = neg ? -longint'(quot[63:0]) : longint'(quot[63:0]);
      t = x + q;
      if (t > longint'(idsa_pkg::VALUE_MAX)) begin
         res.value = idsa_pkg::VALUE_MAX;
         res.sat = 1'b1;
      end else if (t < longint'(idsa_pkg::VALUE_MIN)) begin
         res.value = idsa_pkg::VALUE_MIN;
         res.sat = 1'b1;
      end else begin
         res.value = t[idsa_pkg::VALUE_W-1:0];
      end
      return res;
   endfunction

   function automatic dir_row_type mk_row(int phase, int col, int row,
                                          logic [idsa_pkg::VALUE_W-1:0] x,
                                          logic [idsa_pkg::VALUE_W-1:0] b,
                                          logic [idsa_pkg::VALUE_W-1:0] a,
                                          logic [idsa_pkg::VALUE_W-1:0] l,
                                          logic [idsa_pkg::VALUE_W-1:0] r, bit typed,
                                          logic [idsa_pkg::VALUE_W-1:0] y, logic sat);
      dir_row_type d;
      d.phase = phase;
      d.node.center_value = x;
      d.node.below_value = b;
      d.node.above_value = a;
      d.node.left_value = l;
      d.node.right_value = r;
      d.node.column = idsa_pkg::COORD_W'(col);
      d.node.row = idsa_pkg::COORD_W'(row);
      d.typed = typed;
      d.want.value = y;
      d.want.sat = sat;
      return d;
   endfunction

   function automatic idsa_pkg::idsa_cfg_type dir_cfg(int phase);
      idsa_pkg::idsa_cfg_type c;
      c = '0;
      case (phase)
         1: begin
            c.fourier_number = 31'h0001_0000;
            c.top_robin_term = 31'h0000_8000;
            c.bottom_robin_term = 31'h0000_4000;
            c.left_robin_term = 31'h0000_2000;
            c.right_robin_term = 31'h0000_1000;
            c.wall_neumann_mask = 4'hF;
            c.grid_width = 13'd5;
            c.grid_height = 13'd4;
         end
         2: begin
            c.fourier_number = {idsa_pkg::COEF_W{1'b1}};
            c.top_robin_term = {idsa_pkg::COEF_W{1'b1}};
            c.bottom_robin_term = {idsa_pkg::COEF_W{1'b1}};
            c.left_robin_term = {idsa_pkg::COEF_W{1'b1}};
            c.right_robin_term = {idsa_pkg::COEF_W{1'b1}};
            c.wall_neumann_mask = 4'h0;
            c.grid_width = 13'd0;
            c.grid_height = 13'd1;
         end
         default: begin
            c.fourier_number = 31'h0001_8000;
            c.top_robin_term = 31'h0001_0000;
            c.bottom_robin_term = 31'h0002_0000;
            c.left_robin_term = 31'h0003_0000;
            c.right_robin_term = 31'h0004_0000;
            c.wall_neumann_mask = 4'b0101;
            c.grid_width = 13'd4;
            c.grid_height = 13'd4097;
         end
      endcase
      return c;
   endfunction

   function automatic logic signed [idsa_pkg::VALUE_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return idsa_pkg::VALUE_MAX;
         1: return idsa_pkg::VALUE_MIN;
         2: return '0;
         3: return idsa_pkg::VALUE_W'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [idsa_pkg::COEF_W-1:0] rand_coef();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return {idsa_pkg::COEF_W{1'b1}};
         2: return idsa_pkg::COEF_W'(32'h0001_0000);
         3, 4, 5: return idsa_pkg::COEF_W'($urandom_range(0, 32'h0004_0000));
         6, 7: return idsa_pkg::COEF_W'($urandom_range(0, 32'h0000_4000));
         default: return idsa_pkg::COEF_W'($urandom);
      endcase
   endfunction

   function automatic logic [idsa_pkg::SIDE_W-1:0] rand_side();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return idsa_pkg::SIDE_W'($urandom_range(3, 8));
         6: return idsa_pkg::SIDE_W'($urandom_range(0, 2));
         7: return idsa_pkg::GRID_SIDE_MAX;
         8: return idsa_pkg::SIDE_W'($urandom_range(4097, 8191));
         default: return idsa_pkg::SIDE_W'($urandom_range(0, 8191));
      endcase
   endfunction

   function automatic logic [idsa_pkg::COORD_W-1:0] rand_coord(
      logic [idsa_pkg::SIDE_W-1:0] side
   );
      case ($urandom_range(0, 11))
         0: return '0;
         1: return idsa_pkg::COORD_W'(1);
         2: return idsa_pkg::COORD_W'(side - 2);
         3, 4: return idsa_pkg::COORD_W'(side - 1);
         5: begin
            if (side < idsa_pkg::GRID_SIDE_MAX)
               return idsa_pkg::COORD_W'($urandom_range(side, 4095));
            return idsa_pkg::COORD_W'($urandom);
         end
         default: return idsa_pkg::COORD_W'($urandom_range(0, side - 1));
      endcase
   endfunction

   function automatic idsa_pkg::idsa_cfg_type rand_cfg();
      idsa_pkg::idsa_cfg_type c;
      c.fourier_number = rand_coef();
      c.top_robin_term = rand_coef();
      c.bottom_robin_term = rand_coef();
      c.left_robin_term = rand_coef();
      c.right_robin_term = rand_coef();
      c.wall_neumann_mask = idsa_pkg::MASK_W'($urandom_range(0, 15));
      c.grid_width = rand_side();
      c.grid_height = rand_side();
      return c;
   endfunction

   function automatic int idle_draw(bit quiet);
      if (quiet) return 0;
      return $urandom_range(0, 6);
   endfunction

   task automatic csr_write(idsa_pkg::idsa_csr_type idx, logic [idsa_pkg::COEF_W-1:0] d);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= d;
      @(posedge clock);
   endtask

   task automatic apply_config(idsa_pkg::idsa_cfg_type c, bit junk);
      logic [idsa_pkg::COEF_W-1:0] upper_side, upper_mask;
      upper_side = junk ? (idsa_pkg::COEF_W'($urandom) << idsa_pkg::SIDE_W) : '0;
      upper_mask = junk ? (idsa_pkg::COEF_W'($urandom) << idsa_pkg::MASK_W) : '0;
      csr_write(idsa_pkg::CSR_FOURIER_NUMBER, c.fourier_number);
      csr_write(idsa_pkg::CSR_TOP_ROBIN_TERM, c.top_robin_term);
      csr_write(idsa_pkg::CSR_BOTTOM_ROBIN_TERM, c.bottom_robin_term);
      csr_write(idsa_pkg::CSR_LEFT_ROBIN_TERM, c.left_robin_term);
      csr_write(idsa_pkg::CSR_RIGHT_ROBIN_TERM, c.right_robin_term);
      csr_write(idsa_pkg::CSR_WALL_NEUMANN_MASK,
                upper_mask | idsa_pkg::COEF_W'(c.wall_neumann_mask));
      csr_write(idsa_pkg::CSR_GRID_WIDTH, upper_side | idsa_pkg::COEF_W'(c.grid_width));
      csr_write(idsa_pkg::CSR_GRID_HEIGHT, upper_side | idsa_pkg::COEF_W'(c.grid_height));
      csr_write_enable <= 1'b0;
      cfg = c;
   endtask

   // drop valid and hold until every outstanding transaction has returned
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (stencil_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_node(idsa_pkg::idsa_node_type nd, bit typed, op_result_type want);
      int gap;
      if (sender_count % 50 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
      sender_count++;
      gap = idle_draw(sender_quiet);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.center_value <= nd.center_value;
      req_if.below_value <= nd.below_value;
      req_if.above_value <= nd.above_value;
      req_if.left_value <= nd.left_value;
      req_if.right_value <= nd.right_value;
      req_if.column <= nd.column;
      req_if.row <= nd.row;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      stencil_results.push_back(typed ? want : stencil_operator(nd, cfg));
   endtask

   task automatic check_result(logic signed [idsa_pkg::VALUE_W-1:0] got_value,
                               logic got_sat);
      op_result_type want;
      if (stencil_results.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("unexpected result: operator_value %h saturated %b", got_value, got_sat);
      end else begin
         want = stencil_results.pop_front();
         if (got_value !== want.value || got_sat !== want.sat) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("mismatch: expected operator_value %h saturated %b, got %h %b",
                        want.value, want.sat, got_value, got_sat);
         end
      end
   endtask

   initial begin : result_monitor
      int gap;
      int seen;
      bit quiet;
      seen = 0;
      quiet = 1'b0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (seen % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
         seen++;
         gap = idle_draw(quiet);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (rsp_if.valid !== 1'b1) @(posedge clock);
         check_result(rsp_if.operator_value, rsp_if.saturated);
      end
   end

   initial begin : stimulus
      int                          phase;
      int                          counted;
      int                          span;
      int                          k;
      idsa_pkg::idsa_node_type     nd;
      op_result_type               none;
      logic [idsa_pkg::SIDE_W-1:0] w, h;
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= idsa_pkg::CSR_FOURIER_NUMBER;
      csr_write_data <= '0;
      req_if.valid <= 1'b0;
      req_if.center_value <= '0;
      req_if.below_value <= '0;
      req_if.above_value <= '0;
      req_if.left_value <= '0;
      req_if.right_value <= '0;
      req_if.column <= '0;
      req_if.row <= '0;
      none.value = '0;
      none.sat = 1'b0;
      cfg = idsa_pkg::CFG_RESET;

      // reset state: zero Fourier number, every node returns x
      dir_table[0]  = mk_row(0, 1, 1, 32'h0001_2345, 32'h0000_8000, 32'hFFFF_0000,
                             32'h0003_0000, 32'h7FFF_FFFF, 1, 32'h0001_2345, 0);
      dir_table[1]  = mk_row(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000, 32'h8000_0000, 1, 32'h7FFF_FFFF, 0);
      dir_table[2]  = mk_row(0, 2, 2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h8000_0000, 0);
      dir_table[3]  = mk_row(0, 5, 7, 32'hDEAD_BEEF, 32'h1234_5678, 32'h0000_0001,
                             32'hFFFF_FFFF, 32'h5555_5555, 1, 32'hDEAD_BEEF, 0);
      // all Robin walls, 5 x 4 grid
      dir_table[4]  = mk_row(1, 2, 1, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000,
                             32'h0002_0000, 32'h0000_4000, 0, 0, 0);
      dir_table[5]  = mk_row(1, 2, 3, 32'h0002_0000, 32'h0001_0000, 32'h7FFF_FFFF,
                             32'hFFFE_0000, 32'h0000_C000, 0, 0, 0);
      dir_table[6]  = mk_row(1, 2, 0, 32'hFFFF_8000, 32'h8000_0000, 32'h0003_0000,
                             32'h0000_1000, 32'h0001_0000, 0, 0, 0);
      dir_table[7]  = mk_row(1, 0, 2, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000,
                             32'h7FFF_FFFF, 32'h0000_8000, 0, 0, 0);
      dir_table[8]  = mk_row(1, 4, 2, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002,
                             32'h0001_0000, 32'h8000_0000, 0, 0, 0);
      dir_table[9]  = mk_row(1, 0, 0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0000_8000,
                             32'h7FFF_FFFF, 32'h0000_4000, 0, 0, 0);
      dir_table[10] = mk_row(1, 4, 0, 32'hFFFF_0000, 32'h8000_0000, 32'h0001_0000,
                             32'h0002_0000, 32'h8000_0000, 0, 0, 0);
      dir_table[11] = mk_row(1, 0, 3, 32'h0003_8000, 32'h0000_4000, 32'h1234_5678,
                             32'h8765_4321, 32'h0001_0000, 0, 0, 0);
      dir_table[12] = mk_row(1, 4, 3, 32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF,
                             32'h0000_0000, 32'h7FFF_FFFF, 0, 0, 0);
      // largest Fourier number, Dirichlet walls, sizes below minimum
      dir_table[13] = mk_row(2, 1, 1, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                             32'h0000_0000, 32'h0000_0000, 1, 32'h7FFF_FFFF, 1);
      dir_table[14] = mk_row(2, 1, 1, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000,
                             32'h0000_0000, 32'h0000_0000, 1, 32'h8000_0000, 1);
      dir_table[15] = mk_row(2, 1, 1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                             32'h0000_0000, 32'h0000_0000, 1, 32'h0000_0000, 0);
      dir_table[16] = mk_row(2, 1, 1, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h8000_0000, 1);
      dir_table[17] = mk_row(2, 1, 1, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1);
      dir_table[18] = mk_row(2, 0, 1, 32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h1234_5678, 0);
      dir_table[19] = mk_row(2, 2, 0, 32'h8765_4321, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'h8000_0000, 1, 32'h8765_4321, 0);
      // Robin top and left, Dirichlet bottom and right, height above maximum
      dir_table[20] = mk_row(3, 0, 4095, 32'h0001_0000, 32'h0000_8000, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h0002_0000, 0, 0, 0);
      dir_table[21] = mk_row(3, 3, 4095, 32'hFFFF_0000, 32'h0001_0000, 32'h8000_0000,
                             32'h0000_4000, 32'h7FFF_FFFF, 0, 0, 0);
      dir_table[22] = mk_row(3, 0, 0, 32'h2468_ACE0, 32'h7FFF_FFFF, 32'h0001_0000,
                             32'h8000_0000, 32'h0001_0000, 1, 32'h2468_ACE0, 0);
      dir_table[23] = mk_row(3, 1, 0, 32'hF000_000F, 32'h0000_1000, 32'h0001_0000,
                             32'h0002_0000, 32'h0003_0000, 1, 32'hF000_000F, 0);
      dir_table[24] = mk_row(3, 0, 7, 32'h0000_C000, 32'h0001_0000, 32'h0000_8000,
                             32'h8000_0000, 32'h0002_0000, 0, 0, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      phase = 0;
      for (k = 0; k < DIR_ROWS; k++) begin
         if (dir_table[k].phase != phase) begin
            phase = dir_table[k].phase;
            settle();
            apply_config(dir_cfg(phase), 1'b0);
         end
         send_node(dir_table[k].node, dir_table[k].typed, dir_table[k].want);
      end

      counted = 0;
      while (counted < RANDOM_NODES) begin
         settle();
         apply_config(rand_cfg(), 1'b1);
         w = side_in_use(cfg.grid_width);
         h = side_in_use(cfg.grid_height);
         span = $urandom_range(60, 140);
         for (k = 0; k < span; k++) begin
            nd.center_value = rand_value();
            nd.below_value = rand_value();
            nd.above_value = rand_value();
            nd.left_value = rand_value();
            nd.right_value = rand_value();
            nd.column = rand_coord(w);
            nd.row = rand_coord(h);
            send_node(nd, 1'b0, none);
            counted++;
         end
      end

      settle();
      repeat (16) @(posedge clock);
      if (mismatches == 0 && stencil_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: implicit_diffusion_stencil_apply.f
rtl/idsa_pkg.sv
rtl/idsa_if.sv
rtl/idsa_decode.sv
rtl/idsa_diff.sv
rtl/idsa_scale.sv
rtl/implicit_diffusion_stencil_apply.sv
rtl/idsa_checker.sv
bench/tb_top.sv
